@@ src/assert_macros.svh @@
// Shared assertion shorthand for the cache checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property every clock edge outside reset
`define CHK_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check an implication every clock edge outside reset
`define CHK_IMPLIES(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

`endif

@@ src/dmkvc_pkg.sv @@
package dmkvc_pkg;

   localparam int KeyBits = 64;
   localparam int CntBits = 32;
   localparam int DivCntBits = $clog2(KeyBits);

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_STORE  = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   localparam logic [1:0] CSR_KEY_KIND    = 2'd0;
   localparam logic [1:0] CSR_NUM_ENTRIES = 2'd1;
   localparam logic [1:0] CSR_EMPTY_KEY   = 2'd2;

   localparam logic [1:0] KIND_U32 = 2'd0;
   localparam logic [1:0] KIND_S64 = 2'd1;

   localparam logic [1:0]  KindReset    = KIND_S64;
   localparam logic [10:0] EntriesReset = 11'd1021;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_DIV,
      ST_READ,
      ST_CHECK,
      ST_CLEAR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load_req;
      logic div_step;
      logic init_wr;
      logic clr_wr;
      logic check;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic init_last;
      logic clr_last;
   } status_type;

   function automatic logic [KeyBits-1:0] key_mask(input logic [1:0] kind);
      return (kind == KIND_U32) ? {{(KeyBits-32){1'b0}}, {32{1'b1}}} : {KeyBits{1'b1}};
   endfunction

   function automatic logic [CntBits-1:0] sat_inc(input logic [CntBits-1:0] c);
      return (c == {CntBits{1'b1}}) ? c : c + 1'b1;
   endfunction

endpackage

@@ src/dmkvc_ram.sv @@
module dmkvc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ src/dmkvc_ctrl.sv @@
module dmkvc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  dmkvc_pkg::op_type    req_op,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  dmkvc_pkg::status_type status,
   output dmkvc_pkg::cmd_type   cmd
);
   import dmkvc_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT:  if (status.init_last) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_op)
                  OP_LOOKUP, OP_STORE: state_in = ST_DIV;
                  OP_CLEAR:            state_in = ST_CLEAR;
                  default:             state_in = ST_DONE;
               endcase
            end
         end
         ST_DIV:   if (status.div_last) state_in = ST_READ;
         ST_READ:  state_in = ST_CHECK;
         ST_CHECK: state_in = ST_DONE;
         ST_CLEAR: if (status.clr_last) state_in = ST_DONE;
         ST_DONE:  if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_INIT;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_INIT:  cmd.init_wr = 1'b1;
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load_req = req_valid;
         end
         ST_DIV:   cmd.div_step = 1'b1;
         ST_CHECK: cmd.check = 1'b1;
         ST_CLEAR: cmd.clr_wr = 1'b1;
         ST_DONE:  cmd.load_rsp = !rsp_valid_ff || rsp_ready;
         default:  cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ src/dmkvc_dp.sv @@
module dmkvc_dp #(
   parameter int TABLE_DEPTH = 1024,
   parameter int VALUE_BITS  = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  dmkvc_pkg::cmd_type                 cmd,
   output dmkvc_pkg::status_type              status,
   input  logic                               csr_we,
   input  logic [1:0]                         csr_index,
   input  logic [63:0]                        csr_wdata,
   input  dmkvc_pkg::op_type                  req_op,
   input  logic [63:0]                        req_key,
   input  logic [63:0]                        req_store_value,
   output logic                               rsp_hit,
   output logic [63:0]                        rsp_read_value,
   output logic                               rsp_overwrote,
   output logic                               rsp_updated,
   output logic [31:0]                        rsp_hit_count,
   output logic [31:0]                        rsp_store_count,
   output logic [31:0]                        rsp_update_count,
   output logic [31:0]                        rsp_overwrite_count
);
   import dmkvc_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int EW = AW + 1;

   logic [1:0]            key_kind_ff;
   logic [10:0]           num_entries_ff;
   logic [KeyBits-1:0]    empty_key_ff;

   op_type                op_ff;
   logic [KeyBits-1:0]    key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic                  neg_ff;
   logic [KeyBits-1:0]    dvd_ff;
   logic [EW-1:0]         rem_ff, rem_in;
   logic [DivCntBits-1:0] div_cnt_ff;
   logic [AW-1:0]         sweep_ff;

   logic [CntBits-1:0] hits_ff, stores_ff, updates_ff, overwrites_ff;
   logic               res_hit_ff, res_ow_ff, res_up_ff;
   logic [63:0]        res_rv_ff;

   logic [KeyBits-1:0]    km, kin, mag;
   logic [EW-1:0]         eff;
   logic [EW:0]           trial;
   logic [AW-1:0]         idx;
   logic [KeyBits-1:0]    rd_key;
   logic [VALUE_BITS-1:0] rd_val;
   logic                  key_match, key_empty, store_chk;
   logic                  key_we, val_we;
   logic [AW-1:0]         key_waddr;
   logic [KeyBits-1:0]    key_wdata;
   logic [VALUE_BITS-1:0] val_wdata;

   assign km  = key_mask(key_kind_ff);
   assign kin = req_key & km;
   assign mag = (key_kind_ff == KIND_S64 && req_key[63]) ? (~req_key + 1'b1) : kin;

   always_comb begin
      if (num_entries_ff == 11'd0) begin
         eff = EW'(1);
      end else if (32'(num_entries_ff) > TABLE_DEPTH) begin
         eff = EW'(TABLE_DEPTH);
      end else begin
         eff = EW'(num_entries_ff);
      end
   end

   // restoring division, one quotient bit per cycle; only the remainder is kept
   assign trial = {rem_ff, dvd_ff[KeyBits-1]};
   assign rem_in = (trial >= {1'b0, eff}) ? EW'(trial - {1'b0, eff}) : trial[EW-1:0];

   // negative signed keys take the non-negative remainder
   assign idx = (neg_ff && rem_ff != '0) ? AW'(eff - rem_ff) : AW'(rem_ff);

   assign status.div_last  = (div_cnt_ff == {DivCntBits{1'b1}});
   assign status.init_last = (sweep_ff == {AW{1'b1}});
   assign status.clr_last  = ({1'b0, sweep_ff} == eff - 1'b1);

   assign store_chk = cmd.check && op_ff == OP_STORE;
   assign key_we    = cmd.init_wr || cmd.clr_wr || store_chk;
   assign val_we    = cmd.init_wr || store_chk;
   assign key_waddr = (cmd.init_wr || cmd.clr_wr) ? sweep_ff : idx;

   always_comb begin
      if (cmd.init_wr) begin
         key_wdata = '0;
      end else if (cmd.clr_wr) begin
         key_wdata = empty_key_ff & km;
      end else begin
         key_wdata = key_ff;
      end
   end

   assign val_wdata = cmd.init_wr ? '0 : value_ff;

   dmkvc_ram #(.WIDTH(KeyBits), .DEPTH(TABLE_DEPTH)) u_keys (
      .clock (clock),
      .we    (key_we),
      .waddr (key_waddr),
      .wdata (key_wdata),
      .raddr (idx),
      .rdata (rd_key)
   );

   dmkvc_ram #(.WIDTH(VALUE_BITS), .DEPTH(TABLE_DEPTH)) u_values (
      .clock (clock),
      .we    (val_we),
      .waddr (key_waddr),
      .wdata (val_wdata),
      .raddr (idx),
      .rdata (rd_val)
   );

   assign key_match = (rd_key & km) == key_ff;
   assign key_empty = (rd_key & km) == (empty_key_ff & km);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_kind_ff    <= KindReset;
         num_entries_ff <= EntriesReset;
         empty_key_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KEY_KIND:    key_kind_ff    <= csr_wdata[1:0];
            CSR_NUM_ENTRIES: num_entries_ff <= csr_wdata[10:0];
            CSR_EMPTY_KEY:   empty_key_ff   <= csr_wdata;
            default:         key_kind_ff    <= key_kind_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff      <= '0;
         div_cnt_ff    <= '0;
         hits_ff       <= '0;
         stores_ff     <= '0;
         updates_ff    <= '0;
         overwrites_ff <= '0;
      end else begin
         if (cmd.load_req) begin
            sweep_ff   <= '0;
            div_cnt_ff <= '0;
         end else begin
            if (cmd.init_wr || cmd.clr_wr) sweep_ff <= sweep_ff + 1'b1;
            if (cmd.div_step) div_cnt_ff <= div_cnt_ff + 1'b1;
         end
         if (cmd.check) begin
            if (op_ff == OP_LOOKUP && key_match) hits_ff <= sat_inc(hits_ff);
            if (store_chk) begin
               stores_ff <= sat_inc(stores_ff);
               if (key_match) begin
                  updates_ff <= sat_inc(updates_ff);
               end else if (!key_empty) begin
                  overwrites_ff <= sat_inc(overwrites_ff);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff      <= req_op;
         key_ff     <= kin;
         value_ff   <= req_store_value[VALUE_BITS-1:0];
         neg_ff     <= key_kind_ff == KIND_S64 && req_key[63];
         dvd_ff     <= mag;
         rem_ff     <= '0;
         res_hit_ff <= 1'b0;
         res_ow_ff  <= 1'b0;
         res_up_ff  <= 1'b0;
         res_rv_ff  <= '0;
      end else begin
         if (cmd.div_step) begin
            dvd_ff <= {dvd_ff[KeyBits-2:0], 1'b0};
            rem_ff <= rem_in;
         end
         if (cmd.check) begin
            res_hit_ff <= op_ff == OP_LOOKUP && key_match;
            res_rv_ff  <= (op_ff == OP_LOOKUP && key_match) ? 64'(rd_val) : '0;
            res_up_ff  <= store_chk && key_match;
            res_ow_ff  <= store_chk && !key_match && !key_empty;
         end
      end
   end

   // hold the result word until the receiver takes it
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_hit             <= res_hit_ff;
         rsp_read_value      <= res_rv_ff;
         rsp_overwrote       <= res_ow_ff;
         rsp_updated         <= res_up_ff;
         rsp_hit_count       <= hits_ff;
         rsp_store_count     <= stores_ff;
         rsp_update_count    <= updates_ff;
         rsp_overwrite_count <= overwrites_ff;
      end
   end

endmodule

@@ src/direct_mapped_key_value_cache.sv @@
// Direct-mapped key/value cache.
// Request channel (req_valid/req_ready) carries one word: req_type (lookup, store,
// clear, no-op), req_key and req_store_value. Response channel (rsp_valid/rsp_ready)
// returns one word per request: hit, read_value, overwrote, updated and the four
// saturating counters as they stand after the request.
// Lookup and store: the bit-serial modulo unit forms the slot index, then the
// table is read, then compared and written, then the response register is loaded.
// A new request is taken only once the previous one has loaded its response.
// Clear: writes the empty key into every slot in use (num_entries).
// The response register parts the two channels: a new request is taken while the
// previous response waits; its work runs, then it holds until rsp_ready frees the
// response register.
// Reset: registers take their reset values and a clearing pass writes every table
// entry, during which req_ready stays low. csr_we writes are taken at any time,
// but only while the block is idle do they have defined effect.
module direct_mapped_key_value_cache #(
   parameter int TABLE_DEPTH = 1024,
   parameter int VALUE_BITS  = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [63:0] req_key,
   input  logic [63:0] req_store_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_hit,
   output logic [63:0] rsp_read_value,
   output logic        rsp_overwrote,
   output logic        rsp_updated,
   output logic [31:0] rsp_hit_count,
   output logic [31:0] rsp_store_count,
   output logic [31:0] rsp_update_count,
   output logic [31:0] rsp_overwrite_count
);
   import dmkvc_pkg::*;

   cmd_type    cmd;
   status_type status;
   op_type     req_op;

   assign req_op = op_type'(req_type);

   dmkvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dmkvc_dp #(.TABLE_DEPTH(TABLE_DEPTH), .VALUE_BITS(VALUE_BITS)) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_op              (req_op),
      .req_key             (req_key),
      .req_store_value     (req_store_value),
      .rsp_hit             (rsp_hit),
      .rsp_read_value      (rsp_read_value),
      .rsp_overwrote       (rsp_overwrote),
      .rsp_updated         (rsp_updated),
      .rsp_hit_count       (rsp_hit_count),
      .rsp_store_count     (rsp_store_count),
      .rsp_update_count    (rsp_update_count),
      .rsp_overwrite_count (rsp_overwrite_count)
   );

endmodule

@@ src/dmkvc_checker.sv @@
`include "assert_macros.svh"

module dmkvc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_hit,
   input logic [63:0] rsp_read_value,
   input logic        rsp_overwrote,
   input logic        rsp_updated,
   input logic [31:0] rsp_store_count,
   input logic [31:0] rsp_update_count
);

   `CHK_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")
   `CHK_IMPLIES(a_flags_excl, clock, reset, rsp_valid, !(rsp_hit && (rsp_overwrote || rsp_updated)) && !(rsp_overwrote && rsp_updated), "conflicting result flags")
   `CHK_IMPLIES(a_miss_zero, clock, reset, rsp_valid && !rsp_hit, rsp_read_value == 64'd0, "read value on a miss")
   `CHK_IMPLIES(a_upd_le_store, clock, reset, rsp_valid, rsp_update_count <= rsp_store_count, "more updates than stores")

endmodule

bind direct_mapped_key_value_cache dmkvc_checker u_chk (.*);
